/* hdl/linear_to_srgb_encode_macros.svh */
// assertion shorthands for the sRGB encoder
// used by the files that carry concurrent checks; no other dependencies
`ifndef LINEAR_TO_SRGB_ENCODE_MACROS_SVH
`define LINEAR_TO_SRGB_ENCODE_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define L2S_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define L2S_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/l2s_pkg.sv */
// shared widths and arithmetic constants for the linear to sRGB encoder
// no dependencies
`timescale 1ns / 1ps

package l2s_pkg;

    localparam int LANES_DEF = 4;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 22;
    localparam int LEAD_W    = 4;
    localparam int STAGES    = 12;

    // input conditioning and linear segment
    localparam logic [IN_W-1:0]  SAT_ONE    = 16'd32768;
    localparam logic [IN_W-1:0]  LINE_LIMIT = 16'd102;
    localparam logic [30:0]      LINE_GAIN  = 31'd13494682;

    // log2 polynomial, Q5.23 result
    localparam logic [28:0]        LOG_C3 = 29'd10184;
    localparam logic signed [32:0] LOG_C2 = 33'sd1230540898;
    localparam logic signed [33:0] LOG_C1 = 34'sd1521822479;
    localparam logic [32:0]        LOG_C0 = 33'd778821;

    localparam logic [27:0] CURVE_OFFSET = 28'd15280658;

    // exp2 polynomial on the top 15 fraction bits
    localparam logic [30:0] EXP_C3 = 31'd10366;
    localparam logic [30:0] EXP_C2 = 31'd964355891;
    localparam logic [30:0] EXP_C1 = 31'd747760043;

    // output scaling: value * 2^14 = mant * 2^(ex - EXP_BIAS)
    localparam logic [4:0]  EXP_BIAS = 5'd9;
    localparam logic [4:0]  EXP_MAX  = 5'd20;

    localparam logic signed [35:0] SRGB_SUB  = 36'sd229786;
    localparam logic signed [35:0] OUT_MAX_S = 36'sd4194303;
    localparam logic [OUT_W-1:0]   OUT_MAX   = 22'h3FFFFF;

endpackage

/* hdl/l2s_if.sv */
// valid/ready channel interfaces for the encoder input and output
// depends on l2s_pkg
`timescale 1ns / 1ps

interface l2s_in_if #(
    parameter int LANES = l2s_pkg::LANES_DEF
) ();
    import l2s_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [LANES*IN_W-1:0]   linear;

    modport source (output valid, output linear, input ready);
    modport sink   (input valid, input linear, output ready);
endinterface

interface l2s_out_if #(
    parameter int LANES = l2s_pkg::LANES_DEF
) ();
    import l2s_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [LANES*OUT_W-1:0]  srgb;

    modport source (output valid, output srgb, input ready);
    modport sink   (input valid, input srgb, output ready);
endinterface

/* hdl/l2s_lane.sv */
// one encoder lane: twelve-stage datapath from UQ1.15 linear to UQ8.14 sRGB
// depends on l2s_pkg; stage enables come from the top-level valid chain
`timescale 1ns / 1ps

module l2s_lane (
    input  logic                        i_clk,
    input  logic [l2s_pkg::STAGES-1:0]  i_en,
    input  logic [l2s_pkg::IN_W-1:0]    i_linear,
    output logic [l2s_pkg::OUT_W-1:0]   o_srgb
);
    import l2s_pkg::*;

    // combinational terms
    logic [IN_W-1:0]     w_v;
    logic [LEAD_W-1:0]   w_lead;
    logic [IN_W-1:0]     w_frac;
    logic [IN_W-1:0]     w_norm;
    logic [28:0]         w_p1;
    logic signed [32:0]  w_a1;
    logic signed [31:0]  w_p2;
    logic signed [33:0]  w_a2;
    logic [31:0]         w_p3;
    logic [32:0]         w_a3;
    logic [29:0]         w_q1;
    logic [29:0]         w_q3;
    logic [29:0]         w_q6;
    logic [30:0]         w_p7;
    logic [30:0]         w_p8;
    logic [31:0]         w_p9;
    logic [31:0]         w_z3;
    logic [4:0]          w_exc;
    logic [3:0]          w_sh;
    logic [23:0]         w_q;
    logic [23:0]         w_rem;
    logic [23:0]         w_half;
    logic                w_up;
    logic signed [35:0]  w_diff;
    logic [OUT_W-1:0]    w_curve;

    // next values
    logic                n0_line;
    logic [6:0]          n0_v7;
    logic [LEAD_W-1:0]   n0_lead;
    logic [14:0]         n0_m;
    logic signed [15:0]  n1_y1;
    logic [OUT_W-1:0]    n1_lin;
    logic [16:0]         n2_y2;
    logic [27:0]         n3_log;
    logic [29:0]         n4_q;
    logic [29:0]         n5_q;
    logic [27:0]         n6_x;
    logic [13:0]         n7_z1;
    logic [15:0]         n8_z2;
    logic [23:0]         n9_mant;
    logic [34:0]         n10_r;
    logic [OUT_W-1:0]    n11_out;

    // stage registers
    logic [10:0]         r_line;
    logic [OUT_W-1:0]    r_lin [1:10];
    logic [6:0]          r0_v7;
    logic [LEAD_W-1:0]   r0_lead, r1_lead, r2_lead;
    logic [14:0]         r0_m, r1_m, r2_m;
    logic signed [15:0]  r1_y1;
    logic [16:0]         r2_y2;
    logic [27:0]         r3_log, r4_log, r5_log;
    logic [29:0]         r4_q, r5_q;
    logic [27:0]         r6_x;
    logic [14:0]         r7_m2, r8_m2;
    logic [4:0]          r7_ex, r8_ex, r9_ex;
    logic [13:0]         r7_z1;
    logic [15:0]         r8_z2;
    logic [23:0]         r9_mant;
    logic [34:0]         r10_r;
    logic [OUT_W-1:0]    r11_out;

    always_comb begin
        // saturate, pick segment, find the leading one and normalize
        w_v     = (i_linear > SAT_ONE) ? SAT_ONE : i_linear;
        n0_line = (w_v <= LINE_LIMIT);
        n0_v7   = w_v[6:0];
        w_lead  = '0;
        for (int b = 0; b < IN_W; b++) begin
            if (w_v[b]) begin
                w_lead = LEAD_W'(b);
            end
        end
        w_frac  = w_v & ~(16'd1 << w_lead);
        w_norm  = w_frac << (4'd15 - w_lead);
        n0_lead = w_lead;
        n0_m    = w_norm[14:0];

        // log2 polynomial, one product per stage
        w_p1   = 29'(r0_m) * LOG_C3;
        w_a1   = $signed({4'b0, w_p1}) - LOG_C2;
        n1_y1  = 16'(w_a1 >>> 16);
        n1_lin = OUT_W'((31'(r0_v7) * LINE_GAIN) >> 13);

        w_p2   = 32'(r1_y1) * $signed({17'b0, r1_m});
        w_a2   = 34'(w_p2) + LOG_C1;
        n2_y2  = 17'(w_a2 >>> 15);

        w_p3   = 32'(r2_y2) * 32'(r2_m);
        w_a3   = 33'(w_p3) + LOG_C0;
        n3_log = {1'b0, r2_lead, 23'd0} + 28'(w_a3 >> 7);

        // shift-add divide by 2.4, split over three stages
        w_q1 = 30'(r3_log) + 30'(r3_log >> 2);
        n4_q = w_q1 + (w_q1 >> 4);
        w_q3 = r4_q + (r4_q >> 8);
        n5_q = w_q3 + (w_q3 >> 16);
        w_q6 = (r5_q >> 1) + 30'(r5_log);
        n6_x = 28'(w_q6 >> 2) + CURVE_OFFSET;

        // exp2 polynomial on the fraction
        w_p7    = 31'(r6_x[22:8]) * EXP_C3;
        n7_z1   = 14'((w_p7 + EXP_C2) >> 17);
        w_p8    = 31'(r7_z1) * 31'(r7_m2);
        n8_z2   = 16'((w_p8 + EXP_C1) >> 15);
        w_p9    = 32'(r8_z2) * 32'(r8_m2);
        w_z3    = w_p9 >> 7;
        n9_mant = {1'b1, w_z3[22:0]};

        // scale to UQ21.14, round half to even when bits drop out
        w_exc  = (r9_ex > EXP_MAX) ? EXP_MAX : r9_ex;
        w_sh   = '0;
        w_q    = '0;
        w_rem  = '0;
        w_half = '0;
        w_up   = 1'b0;
        if (w_exc < EXP_BIAS) begin
            w_sh   = 4'(EXP_BIAS - w_exc);
            w_q    = r9_mant >> w_sh;
            w_rem  = r9_mant & ((24'd1 << w_sh) - 24'd1);
            w_half = 24'd1 << (w_sh - 4'd1);
            w_up   = (w_rem > w_half) || ((w_rem == w_half) && w_q[0]);
            n10_r  = 35'(w_q) + 35'(w_up);
        end else begin
            n10_r  = 35'(r9_mant) << (w_exc - EXP_BIAS);
        end

        // offset, clamp and segment select
        w_diff = $signed({1'b0, r10_r}) - SRGB_SUB;
        if (w_diff < 0) begin
            w_curve = '0;
        end else if (w_diff > OUT_MAX_S) begin
            w_curve = OUT_MAX;
        end else begin
            w_curve = w_diff[OUT_W-1:0];
        end
        n11_out = r_line[10] ? r_lin[10] : w_curve;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_line[0] <= n0_line;
            r0_v7     <= n0_v7;
            r0_lead   <= n0_lead;
            r0_m      <= n0_m;
        end
        for (int k = 1; k <= 10; k++) begin
            if (i_en[k]) begin
                r_line[k] <= r_line[k-1];
            end
        end
        if (i_en[1]) begin
            r_lin[1] <= n1_lin;
            r1_y1    <= n1_y1;
            r1_lead  <= r0_lead;
            r1_m     <= r0_m;
        end
        for (int k = 2; k <= 10; k++) begin
            if (i_en[k]) begin
                r_lin[k] <= r_lin[k-1];
            end
        end
        if (i_en[2]) begin
            r2_y2   <= n2_y2;
            r2_lead <= r1_lead;
            r2_m    <= r1_m;
        end
        if (i_en[3]) begin
            r3_log <= n3_log;
        end
        if (i_en[4]) begin
            r4_q   <= n4_q;
            r4_log <= r3_log;
        end
        if (i_en[5]) begin
            r5_q   <= n5_q;
            r5_log <= r4_log;
        end
        if (i_en[6]) begin
            r6_x <= n6_x;
        end
        if (i_en[7]) begin
            r7_z1 <= n7_z1;
            r7_m2 <= r6_x[22:8];
            r7_ex <= r6_x[27:23];
        end
        if (i_en[8]) begin
            r8_z2 <= n8_z2;
            r8_m2 <= r7_m2;
            r8_ex <= r7_ex;
        end
        if (i_en[9]) begin
            r9_mant <= n9_mant;
            r9_ex   <= r8_ex;
        end
        if (i_en[10]) begin
            r10_r <= n10_r;
        end
        if (i_en[11]) begin
            r11_out <= n11_out;
        end
    end

    assign o_srgb = r11_out;

endmodule

/* hdl/l2s_merge.sv */
// merges the lane results into one output transfer behind a skid register
// depends on l2s_pkg, l2s_if and the assertion macro header
`timescale 1ns / 1ps
`include "linear_to_srgb_encode_macros.svh"

module l2s_merge #(
    parameter int LANES = l2s_pkg::LANES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [l2s_pkg::OUT_W-1:0]  i_srgb [LANES],
    l2s_out_if.source                  o_out
);
    import l2s_pkg::*;

    logic [LANES*OUT_W-1:0] w_pack;
    logic                   w_up;
    logic                   r_out_vld;
    logic                   r_skid_vld;
    logic [LANES*OUT_W-1:0] r_out;
    logic [LANES*OUT_W-1:0] r_skid;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            w_pack[k*OUT_W +: OUT_W] = i_srgb[k];
        end
    end

    // upstream ready is a register, so the receiver's ready never reaches the pipeline
    assign o_ready = !r_skid_vld;
    assign w_up    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || o_out.ready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= w_up;
            end
        end else if (w_up) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || o_out.ready) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
            end else if (w_up) begin
                r_out <= w_pack;
            end
        end else if (w_up) begin
            r_skid <= w_pack;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.srgb  = r_out;

    `L2S_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_vld, r_out_vld, "skid full with output register empty")
    `L2S_ASSERT_NXT(a_skid_drains, i_clk, i_rst_n, r_skid_vld && o_out.ready, r_out_vld && !r_skid_vld, "skid did not drain on transfer")
    `L2S_ASSERT_NXT(a_stall_captures, i_clk, i_rst_n, r_out_vld && !o_out.ready && w_up, r_skid_vld, "result lost while output stalled")

endmodule

/* hdl/linear_to_srgb_encode.sv */
// linear to sRGB gamma encoder, top level: lane array, valid chain, output merge
// depends on l2s_pkg, l2s_if, l2s_lane, l2s_merge and the assertion macro header
//
// usage:
//   i_in carries LANES linear intensities per transfer, UQ1.15, 16 bits each, lane k in
//   linear[16k+15:16k]; values above 32768 saturate to 1.0.
//   o_out carries LANES sRGB values per transfer, UQ8.14 on a 0 to 255 scale, 22 bits
//   each, lane k in srgb[22k+21:22k].
//   one item per clock sustained while the receiver keeps ready high; every lane has its
//   own twelve-stage datapath with at most two multipliers in a stage, and a result
//   passes the lane stages and then the merge output register on its way to o_out.
//   i_rst_n is synchronous, active low; it empties the pipeline and the output
//   register, and the block takes input as soon as reset is released.
//   when the receiver drops ready the output register and a skid register hold the
//   waiting results; the pipeline keeps accepting until its empty stages fill, then
//   i_in.ready falls, and no item is lost or repeated.
`timescale 1ns / 1ps
`include "linear_to_srgb_encode_macros.svh"

module linear_to_srgb_encode #(
    parameter int LANES = l2s_pkg::LANES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    l2s_in_if.sink      i_in,
    l2s_out_if.source   o_out
);
    import l2s_pkg::*;

    logic [STAGES-1:0]  r_vld;
    logic [STAGES:0]    w_en;
    logic               w_merge_ready;
    logic [OUT_W-1:0]   w_srgb [LANES];

    // a stage may load when it is empty or the stage after it moves
    always_comb begin
        w_en[STAGES] = w_merge_ready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign i_in.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        l2s_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (w_en[STAGES-1:0]),
            .i_linear (i_in.linear[g*IN_W +: IN_W]),
            .o_srgb   (w_srgb[g])
        );
    end

    l2s_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[STAGES-1]),
        .o_ready (w_merge_ready),
        .i_srgb  (w_srgb),
        .o_out   (o_out)
    );

    `L2S_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, i_in.valid && i_in.ready, r_vld[0], "accepted item missing from first stage")
    `L2S_ASSERT_NXT(a_tail_held, i_clk, i_rst_n, r_vld[STAGES-1] && !w_en[STAGES], r_vld[STAGES-1], "finished item dropped while merge was full")

endmodule
